### design/fwhb_pkg.sv
// ============================================================================
// fwhb_pkg
// shared constants and types for the fixed-width histogram binner
// ============================================================================
package fwhb_pkg;

    localparam int MAX_BUCKETS_DEF = 64;

    // request commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_NOBIN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] CFG_SPAN       = 2'd2;
    localparam logic [1:0] CFG_BUCKETS    = 2'd3;

    // configuration reset values
    localparam logic signed [31:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic signed [31:0] RANGE_HIGH_RST = 32'sd4194304;
    localparam logic [30:0]        SPAN_RST       = 31'd65536;
    localparam logic [6:0]         BUCKETS_RST    = 7'd64;

    // span used when the span register holds zero (2.0 in unsigned q15.16)
    localparam logic [30:0] SPAN_FALLBACK = 31'd131072;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
    localparam int          DIV_STEPS     = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_DIV,
        S_LOOKUP,
        S_UPDATE
    } state_t;

endpackage

### design/fixed_width_histogram_binner_core.sv
// ============================================================================
// fixed_width_histogram_binner_core
// equal-width histogram with saturating counts and a serial bucket divider
// ----------------------------------------------------------------------------
// A request (cmd, sample_value) is taken at a clock edge with start high and
// busy low. add and query run a range check state, a 32-step restoring
// division of (value - range_low - 1), or of zero when value equals
// range_low, by the bucket span, a lookup state that also issues the count
// memory read, and an update state that gives the result with done high.
// Out-of-range values answer from the range check state, uncovered values
// from the lookup state. A clear sweeps the count memory one entry a cycle,
// answering after the last entry; an unused command answers on the next cycle.
// Each result shows on status and bucket_total for one cycle with done
// high; the receiver cannot stall, so nothing is held back.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once. They
// must be made only while the block is idle; the block does not enforce this.
// After reset the block runs a clearing pass over all MAX_BUCKETS count
// memory entries with busy high; no result is given for it.
// ============================================================================
module fixed_width_histogram_binner_core #(
    parameter int MAX_BUCKETS = fwhb_pkg::MAX_BUCKETS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] sample_value,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    output logic               done,
    output logic [1:0]         status,
    output logic [31:0]        bucket_total
);
    import fwhb_pkg::*;

    localparam int                IDX_W    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam logic [31:0]       MAX_B32  = 32'(MAX_BUCKETS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_BUCKETS - 1);
    localparam logic [4:0]        LAST_STEP = 5'(DIV_STEPS - 1);

    state_t                  state_reg, state_next;
    logic [1:0]              cmd_reg, cmd_next;
    logic signed [31:0]      value_reg, value_next;
    logic [30:0]             rem_reg, rem_next;
    logic [31:0]             quo_reg, quo_next;
    logic [4:0]              step_reg, step_next;
    logic [IDX_W-1:0]        clr_addr_reg, clr_addr_next;
    logic                    clr_reply_reg, clr_reply_next;
    logic                    done_reg, done_next;
    logic [1:0]              status_reg, status_next;
    logic [31:0]             total_reg, total_next;

    logic signed [31:0]      range_low_reg;
    logic signed [31:0]      range_high_reg;
    logic [30:0]             span_reg;
    logic [6:0]              buckets_reg;

    logic [31:0]             count_mem [MAX_BUCKETS];
    logic [31:0]             rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [31:0]             mem_wdata;
    logic [IDX_W-1:0]        rd_addr;

    logic                    out_of_range;
    logic                    at_low;
    logic [31:0]             dm1;
    logic [30:0]             span_eff;
    logic [32:0]             trial;
    logic                    trial_neg;
    logic [31:0]             n_raw;
    logic [31:0]             n_lim;
    logic                    no_bin;
    logic [31:0]             new_count;

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign bucket_total = total_reg;
    assign rd_addr      = quo_reg[IDX_W-1:0];

    // shared datapath
    assign out_of_range = (value_reg < range_low_reg) || (value_reg > range_high_reg);
    assign at_low       = (value_reg == range_low_reg);
    assign dm1          = value_reg[31:0] + ~range_low_reg[31:0];
    assign span_eff     = (span_reg == 31'd0) ? SPAN_FALLBACK : span_reg;
    assign trial        = {1'b0, rem_reg, quo_reg[31]} - {2'b00, span_eff};
    assign trial_neg    = trial[32];
    assign n_raw        = {25'd0, buckets_reg};
    assign n_lim        = (n_raw == 32'd0) ? 32'd1 : ((n_raw > MAX_B32) ? MAX_B32 : n_raw);
    assign no_bin       = (quo_reg >= n_lim);
    assign new_count    = ((cmd_reg == CMD_ADD) && (rd_data_reg != COUNT_MAX))
                          ? rd_data_reg + 32'd1 : rd_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_ADD, CMD_QUERY: state_next = S_CHECK;
                        CMD_CLEAR:          state_next = S_CLEAR;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_CHECK:  state_next = out_of_range ? S_IDLE : S_DIV;
            S_DIV:
            begin
                if (step_reg == LAST_STEP)
                    state_next = S_LOOKUP;
            end
            S_LOOKUP: state_next = no_bin ? S_IDLE : S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        clr_addr_next  = clr_addr_reg;
        clr_reply_next = clr_reply_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        total_next     = total_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = 32'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    value_next = sample_value;
                    case (cmd)
                        CMD_ADD, CMD_QUERY: ;
                        CMD_CLEAR:
                        begin
                            clr_addr_next  = '0;
                            clr_reply_next = 1'b1;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_OK;
                            total_next  = 32'd0;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_IDX)
                begin
                    clr_addr_next  = '0;
                    clr_reply_next = 1'b0;
                    done_next      = clr_reply_reg;
                    status_next    = STAT_OK;
                    total_next     = 32'd0;
                end
            end
            S_CHECK:
            begin
                if (out_of_range)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_RANGE;
                    total_next  = 32'd0;
                end
                else
                begin
                    rem_next  = 31'd0;
                    quo_next  = at_low ? 32'd0 : dm1;
                    step_next = 5'd0;
                end
            end
            S_DIV:
            begin
                rem_next  = trial_neg ? {rem_reg[29:0], quo_reg[31]} : trial[30:0];
                quo_next  = {quo_reg[30:0], ~trial_neg};
                step_next = step_reg + 5'd1;
            end
            S_LOOKUP:
            begin
                if (no_bin)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOBIN;
                    total_next  = 32'd0;
                end
            end
            S_UPDATE:
            begin
                mem_we      = (cmd_reg == CMD_ADD);
                mem_waddr   = rd_addr;
                mem_wdata   = new_count;
                done_next   = 1'b1;
                status_next = STAT_OK;
                total_next  = new_count;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            step_reg       <= 5'd0;
            clr_addr_reg   <= '0;
            clr_reply_reg  <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= STAT_OK;
            total_reg      <= 32'd0;
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
            span_reg       <= SPAN_RST;
            buckets_reg    <= BUCKETS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            total_reg     <= total_next;
            if (wr_en)
            begin
                case (wr_index)
                    CFG_RANGE_LOW:  range_low_reg  <= wr_data;
                    CFG_RANGE_HIGH: range_high_reg <= wr_data;
                    CFG_SPAN:       span_reg       <= wr_data[30:0];
                    CFG_BUCKETS:    buckets_reg    <= wr_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // request payload and divider
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            count_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= count_mem[rd_addr];
    end

endmodule

### design/fwhb_checker.sv
// ============================================================================
// fwhb_checker
// port-level checks for the histogram binner, bound to the top level
// ============================================================================
module fwhb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  cmd,
    input logic        done,
    input logic [1:0]  status,
    input logic [31:0] bucket_total
);
    import fwhb_pkg::*;

    // a result only shows once the block is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // a real command keeps the block busy after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_ADD || cmd == CMD_QUERY || cmd == CMD_CLEAR))
        |=> busy)
        else $error("request taken but block not busy");

    // failed requests (out of range or no bin) report a zero total
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (bucket_total == 32'd0))
        else $error("nonzero total on failed lookup");

    // status carries a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STAT_OK || status == STAT_RANGE || status == STAT_NOBIN))
        else $error("undefined status code");

endmodule

bind fixed_width_histogram_binner_core fwhb_checker u_fwhb_checker (.*);
